[sv/swsr_pkg.sv]
package swsr_pkg;

   localparam int CFG_W      = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int EDGE_W     = 7;
   localparam int FRAME_BITS = 40;
   localparam int BYTE_W     = 8;
   localparam int POS_W      = 6;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 48;

   // first data edge of the bit cells
   localparam logic [EDGE_W-1:0] FIRST_DATA_EDGE = 7'd3;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_START_LOW     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RELEASE       = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_EDGE_TIMEOUT  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ONE_THRESHOLD = 2'd3;

   // register reset values
   localparam logic [CFG_W-1:0] START_LOW_RESET     = 16'd18000;
   localparam logic [CFG_W-1:0] RELEASE_RESET       = 16'd40;
   localparam logic [CFG_W-1:0] EDGE_TIMEOUT_RESET  = 16'd150;
   localparam logic [CFG_W-1:0] ONE_THRESHOLD_RESET = 16'd50;

   // read status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT  = 2'd2;

   typedef enum logic [3:0] {
      PHASE_IDLE    = 4'b0001,
      PHASE_LOW     = 4'b0010,
      PHASE_RELEASE = 4'b0100,
      PHASE_MEASURE = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [CFG_W-1:0] start_low_ticks;
      logic [CFG_W-1:0] release_ticks;
      logic [CFG_W-1:0] edge_timeout_ticks;
      logic [CFG_W-1:0] one_threshold_ticks;
   } cfg_type;

   typedef struct packed {
      logic              drive_low;
      logic              busy_res;
      logic              done_res;
      logic [1:0]        read_status;
      logic [BYTE_W-1:0] humidity_whole;
      logic [BYTE_W-1:0] humidity_fraction;
      logic [BYTE_W-1:0] temperature_whole;
      logic [BYTE_W-1:0] temperature_fraction;
      logic [BYTE_W-1:0] sum_byte;
   } result_type;

endpackage

[sv/swsr_csr.sv]
module swsr_csr
   import swsr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_addr)
            CSR_START_LOW:     cfg_in.start_low_ticks     = csr_data;
            CSR_RELEASE:       cfg_in.release_ticks       = csr_data;
            CSR_EDGE_TIMEOUT:  cfg_in.edge_timeout_ticks  = csr_data;
            CSR_ONE_THRESHOLD: cfg_in.one_threshold_ticks = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_low_ticks     <= START_LOW_RESET;
         cfg_ff.release_ticks       <= RELEASE_RESET;
         cfg_ff.edge_timeout_ticks  <= EDGE_TIMEOUT_RESET;
         cfg_ff.one_threshold_ticks <= ONE_THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[sv/swsr_core.sv]
module swsr_core
   import swsr_pkg::*;
#(
   parameter int TIMER_WIDTH = 16,
   parameter int FRAME_EDGES = 83
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       func,
   input  logic       line_level,
   input  cfg_type    cfg,
   output result_type result
);

   localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
   localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};
   localparam logic [EDGE_W-1:0] LAST_EDGE = EDGE_W'(FRAME_EDGES);

   phase_type                phase_ff, phase_in, phase_cur;
   logic [TIMER_WIDTH-1:0]   tick_ff, tick_in, tick_cur, elapsed;
   logic [EDGE_W-1:0]        edge_ff, edge_in, edge_cur, edge_next, data_edge;
   logic                     last_ff, last_in;
   logic [FRAME_BITS-1:0]    frame_ff, frame_in, frame_cur, frame_new;
   logic [POS_W-1:0]         bit_pos;
   logic [BYTE_W-1:0]        sum;

   always_comb begin
      phase_cur = phase_ff;
      tick_cur  = tick_ff;
      edge_cur  = edge_ff;
      frame_cur = frame_ff;
      if (phase_ff == PHASE_IDLE && func) begin
         phase_cur = PHASE_LOW;
         tick_cur  = '0;
         edge_cur  = '0;
         frame_cur = '0;
      end

      elapsed   = (tick_cur != TMAX) ? tick_cur + 1'b1 : TMAX;
      edge_next = edge_cur + 1'b1;
      data_edge = edge_cur - FIRST_DATA_EDGE;
      bit_pos   = data_edge[POS_W:1];

      // data bits are timed on the level after each odd edge count from the first data edge on, msb first
      frame_new = frame_cur;
      if (edge_cur >= FIRST_DATA_EDGE && edge_cur[0] && bit_pos < POS_W'(FRAME_BITS) &&
          CMP_W'(elapsed) > CMP_W'(cfg.one_threshold_ticks)) begin
         frame_new[POS_W'(FRAME_BITS - 1) - bit_pos] = 1'b1;
      end

      sum = frame_new[39:32] + frame_new[31:24] + frame_new[23:16] + frame_new[15:8];

      phase_in = phase_cur;
      tick_in  = tick_cur;
      edge_in  = edge_cur;
      last_in  = last_ff;
      frame_in = frame_cur;
      result   = '0;

      unique case (phase_cur)
         PHASE_IDLE: begin
         end
         PHASE_LOW: begin
            result.drive_low = 1'b1;
            result.busy_res  = 1'b1;
            if (CMP_W'(tick_cur) >= CMP_W'(cfg.start_low_ticks) || tick_cur == TMAX) begin
               tick_in  = '0;
               phase_in = PHASE_RELEASE;
            end else begin
               tick_in = tick_cur + 1'b1;
            end
         end
         PHASE_RELEASE: begin
            result.busy_res = 1'b1;
            if (CMP_W'(tick_cur) >= CMP_W'(cfg.release_ticks) || tick_cur == TMAX) begin
               tick_in  = '0;
               phase_in = PHASE_MEASURE;
               last_in  = line_level;
            end else begin
               tick_in = tick_cur + 1'b1;
            end
         end
         PHASE_MEASURE: begin
            result.busy_res = 1'b1;
            if (line_level != last_ff) begin
               frame_in = frame_new;
               last_in  = line_level;
               tick_in  = '0;
               edge_in  = edge_next;
               if (edge_next >= LAST_EDGE) begin
                  result.busy_res             = 1'b0;
                  result.done_res             = 1'b1;
                  result.read_status          = (sum == frame_new[7:0]) ? STATUS_OK
                                                                        : STATUS_CHECKSUM;
                  result.humidity_whole       = frame_new[39:32];
                  result.humidity_fraction    = frame_new[31:24];
                  result.temperature_whole    = frame_new[23:16];
                  result.temperature_fraction = frame_new[15:8];
                  result.sum_byte             = frame_new[7:0];
                  phase_in                    = PHASE_IDLE;
               end
            end else if (CMP_W'(elapsed) > CMP_W'(cfg.edge_timeout_ticks) ||
                         elapsed == TMAX) begin
               result.busy_res    = 1'b0;
               result.done_res    = 1'b1;
               result.read_status = STATUS_TIMEOUT;
               tick_in            = '0;
               phase_in           = PHASE_IDLE;
            end else begin
               tick_in = elapsed;
            end
         end
         default: begin
            phase_in = PHASE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         tick_ff  <= '0;
         edge_ff  <= '0;
         last_ff  <= 1'b1;
         frame_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         edge_ff  <= edge_in;
         last_ff  <= last_in;
         frame_ff <= frame_in;
      end
   end

endmodule

[sv/single_wire_sensor_reader_top.sv]
// single-wire humidity/temperature sensor reader
//
// every req word is one microsecond tick: tuser is the start request, tdata[0]
// the sampled level of the data line. every accepted tick yields exactly one rsp
// word carrying the line drive, busy/done flags, read status and the five frame
// bytes (bytes and status are zero except on the tick a read finishes).
// registers are written over the csr channel (index 0 start_low, 1 release,
// 2 edge_timeout, 3 one_threshold); csr_ready is tied high, and writes are
// meant to happen only while no read is running.
// the rsp word of an accepted tick passes the input register, then the result
// register. throughput: one tick per cycle while rsp_tready stays high, set by
// the single-pass update of the read sequencer between those two registers.
// a tick may enter while the previous result still waits in the result
// register; when rsp_tready stays low both registers fill and req_tready drops,
// so no tick is lost and the sequencer state only advances on ticks it takes.
// reset: sequencer idle, line released, counters and frame cleared, registers
// back to their default timings, both pipeline stages empty.
module single_wire_sensor_reader_top
   import swsr_pkg::*;
#(
   parameter int TIMER_WIDTH = 16,
   parameter int FRAME_EDGES = 83
)
(
   input  logic                  clock,
   input  logic                  reset,
   // tick channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [0] line_level, rest zero
   input  logic                  req_tuser,  // [0] func (start request)
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] drive_low, [1] busy_res, [2] done_res, [4:3] read_status,
   // [12:5] humidity_whole, [20:13] humidity_fraction, [28:21] temperature_whole,
   // [36:29] temperature_fraction, [44:37] sum_byte, [47:45] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_data
);

   cfg_type    cfg;
   result_type result;

   // input stage
   logic in_valid_ff, in_valid_in;
   logic in_func_ff, in_level_ff;

   // result stage
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   // one tick moves from the input stage to the result stage
   logic step;

   assign step        = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || step;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_func_ff  <= req_tuser;
         in_level_ff <= req_tdata[0];
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   swsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   swsr_core #(
      .TIMER_WIDTH (TIMER_WIDTH),
      .FRAME_EDGES (FRAME_EDGES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .func       (in_func_ff),
      .line_level (in_level_ff),
      .cfg        (cfg),
      .result     (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000,
                        rsp_ff.sum_byte,
                        rsp_ff.temperature_fraction,
                        rsp_ff.temperature_whole,
                        rsp_ff.humidity_fraction,
                        rsp_ff.humidity_whole,
                        rsp_ff.read_status,
                        rsp_ff.done_res,
                        rsp_ff.busy_res,
                        rsp_ff.drive_low};

endmodule
